// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge unless dis is true.
`define ERT_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge unless dis is true.
`define ERT_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ert_pkg.sv
// Shared types and constants of the echo round-trip tracker.
`timescale 1ns / 1ps
package ert_pkg;

  localparam int SEQ_W   = 16;
  localparam int TIME_W  = 32;
  localparam int TYPE_W  = 8;
  localparam int RTT_W   = 32;
  localparam int SUM_W   = 48;
  localparam int SQ_W    = 64;
  localparam int CNT_W   = 32;

  localparam logic OP_SEND  = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  localparam logic [TYPE_W-1:0] ECHO_REPLY_TYPE = 8'h02;

  typedef enum logic [1:0] {
    ST_SENT      = 2'd0,
    ST_IN_WINDOW = 2'd1,
    ST_TOO_OLD   = 2'd2,
    ST_NOT_ECHO  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_LOOKUP
  } front_state_t;

  // Classified beat handed from the front end to the statistics back end.
  typedef struct packed {
    status_t            status;
    logic [SEQ_W-1:0]   seq;
    logic [RTT_W-1:0]   rtt;
    logic               is_dup;
    logic               is_reorder;
    logic               count_it;
  } mid_item_t;

  // One finished result beat.
  typedef struct packed {
    status_t            status;
    logic [SEQ_W-1:0]   seq;
    logic [RTT_W-1:0]   rtt;
    logic               is_dup;
    logic               is_reorder;
    logic [RTT_W-1:0]   rtt_min;
    logic [RTT_W-1:0]   rtt_max;
    logic [SUM_W-1:0]   rtt_sum;
    logic [SQ_W-1:0]    rtt_sum_sq;
    logic [CNT_W-1:0]   rtt_count;
    logic [CNT_W-1:0]   dup_total;
    logic [CNT_W-1:0]   reorder_total;
  } res_item_t;

endpackage

// File: rtl/core/ert_fifo.sv
// Small register queue used between the pipeline sections and at the output.
`timescale 1ns / 1ps
module ert_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/core/ert_front.sv
// Front end: accepts beats, owns the send ring and classifies each reply.
`timescale 1ns / 1ps
module ert_front #(
  parameter int TRACK_DEPTH = 1024,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_operation,
  input  logic [ert_pkg::TIME_W-1:0]     in_time_us,
  input  logic [ert_pkg::SEQ_W-1:0]      in_reply_seq,
  input  logic [ert_pkg::TYPE_W-1:0]     in_msg_type,
  input  logic                           mid_full,
  output logic                           mid_push,
  output ert_pkg::mid_item_t             mid_item
);

  localparam int IDX_W = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam int WIN_W = ert_pkg::SEQ_W + 1;

  ert_pkg::front_state_t state_r, state_nxt;

  logic [TIME_BITS:0]            ring_mem [TRACK_DEPTH];
  logic [TIME_BITS:0]            rd_data_r;
  logic [IDX_W-1:0]              rd_addr;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_wa;
  logic [TIME_BITS:0]            mem_wd;

  logic [IDX_W-1:0]              clr_idx_r, clr_idx_nxt;
  logic [ert_pkg::SEQ_W-1:0]     next_seq_r, next_seq_nxt;
  logic [ert_pkg::SEQ_W-1:0]     highest_seq_r, highest_seq_nxt;

  logic                          op_r;
  logic [TIME_BITS-1:0]          time_r;
  logic [ert_pkg::SEQ_W-1:0]     seq_r;
  logic [ert_pkg::TYPE_W-1:0]    type_r;

  logic                          accept;
  logic                          clr_last;
  logic [TIME_BITS-1:0]          stamp;
  logic                          seen;
  logic [ert_pkg::SEQ_W-1:0]     seq_gap;
  logic                          in_win;
  logic                          is_echo;
  logic [TIME_BITS-1:0]          rtt_c;
  logic                          dup_c;
  logic                          reord_c;
  ert_pkg::mid_item_t            item_c;

  assign clr_last = (clr_idx_r == IDX_W'(TRACK_DEPTH - 1));
  assign rd_addr  = in_operation ? in_reply_seq[IDX_W-1:0] : next_seq_r[IDX_W-1:0];

  // Classification of the latched beat against the ring slot read at accept.
  always_comb begin
    stamp   = rd_data_r[TIME_BITS:1];
    seen    = rd_data_r[0];
    seq_gap = next_seq_r - seq_r;
    in_win  = (seq_gap != '0) && (WIN_W'(seq_gap) < WIN_W'(TRACK_DEPTH));
    is_echo = (type_r == ert_pkg::ECHO_REPLY_TYPE);
    rtt_c   = time_r - stamp;
    dup_c   = 1'b0;
    reord_c = 1'b0;
    item_c.status     = ert_pkg::ST_SENT;
    item_c.seq        = seq_r;
    item_c.rtt        = '0;
    item_c.is_dup     = 1'b0;
    item_c.is_reorder = 1'b0;
    item_c.count_it   = 1'b0;
    if (op_r == ert_pkg::OP_REPLY) begin
      if (!is_echo) begin
        item_c.status = ert_pkg::ST_NOT_ECHO;
      end else begin
        if (in_win) begin
          item_c.status = ert_pkg::ST_IN_WINDOW;
          item_c.rtt    = ert_pkg::RTT_W'(rtt_c);
          dup_c         = seen;
        end else begin
          item_c.status = ert_pkg::ST_TOO_OLD;
        end
        reord_c           = !dup_c && (highest_seq_r > seq_r);
        item_c.is_dup     = dup_c;
        item_c.is_reorder = reord_c;
        item_c.count_it   = in_win && !dup_c;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ert_pkg::FS_CLEAR: begin
        if (clr_last) begin
          state_nxt = ert_pkg::FS_IDLE;
        end
      end
      ert_pkg::FS_IDLE: begin
        if (in_push && !mid_full) begin
          state_nxt = ert_pkg::FS_LOOKUP;
        end
      end
      ert_pkg::FS_LOOKUP: begin
        state_nxt = ert_pkg::FS_IDLE;
      end
      default: begin
        state_nxt = ert_pkg::FS_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_full         = 1'b1;
    accept          = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = clr_idx_r;
    mem_wd          = '0;
    mid_push        = 1'b0;
    mid_item        = item_c;
    clr_idx_nxt     = clr_idx_r;
    next_seq_nxt    = next_seq_r;
    highest_seq_nxt = highest_seq_r;
    case (state_r)
      ert_pkg::FS_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ert_pkg::FS_IDLE: begin
        in_full = mid_full;
        accept  = in_push && !mid_full;
        if (accept && (in_operation == ert_pkg::OP_SEND)) begin
          mem_we       = 1'b1;
          mem_wa       = next_seq_r[IDX_W-1:0];
          mem_wd       = {in_time_us[TIME_BITS-1:0], 1'b0};
          next_seq_nxt = next_seq_r + 1'b1;
        end
      end
      ert_pkg::FS_LOOKUP: begin
        mid_push = 1'b1;
        if (item_c.status == ert_pkg::ST_IN_WINDOW) begin
          mem_we = 1'b1;
          mem_wa = seq_r[IDX_W-1:0];
          mem_wd = {stamp, 1'b1};
        end
        if ((op_r == ert_pkg::OP_REPLY) && is_echo && !dup_c && !reord_c) begin
          highest_seq_nxt = seq_r;
        end
      end
      default: begin
        in_full = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ert_pkg::FS_CLEAR;
      clr_idx_r     <= '0;
      next_seq_r    <= '0;
      highest_seq_r <= '0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      next_seq_r    <= next_seq_nxt;
      highest_seq_r <= highest_seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      time_r <= in_time_us[TIME_BITS-1:0];
      seq_r  <= (in_operation == ert_pkg::OP_REPLY) ? in_reply_seq : next_seq_r;
      type_r <= in_msg_type;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/ert_back.sv
// Back end: squares the RTT and keeps the saturating running statistics.
`timescale 1ns / 1ps
module ert_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ert_pkg::mid_item_t   mid_item,
  input  logic                 mid_empty,
  output logic                 mid_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output ert_pkg::res_item_t   res_item
);

  localparam int RTT_W = ert_pkg::RTT_W;
  localparam int SUM_W = ert_pkg::SUM_W;
  localparam int SQ_W  = ert_pkg::SQ_W;
  localparam int CNT_W = ert_pkg::CNT_W;

  logic                 busy_r, busy_nxt;
  ert_pkg::mid_item_t   item_r;
  logic [SQ_W-1:0]      sq_r;

  logic [RTT_W-1:0]     min_r, min_nxt;
  logic [RTT_W-1:0]     max_r, max_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SQ_W-1:0]      sum_sq_r, sum_sq_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     dup_r, dup_nxt;
  logic [CNT_W-1:0]     reord_r, reord_nxt;

  logic [SUM_W:0]       sum_add;
  logic [SQ_W:0]        sq_add;

  // One beat in flight at a time, so the result queue always has room for it.
  assign mid_pop  = !busy_r && !mid_empty && !res_full;
  assign res_push = busy_r;
  assign busy_nxt = mid_pop;

  always_comb begin
    sum_add    = {1'b0, sum_r} + (SUM_W + 1)'(item_r.rtt);
    sq_add     = {1'b0, sum_sq_r} + {1'b0, sq_r};
    min_nxt    = min_r;
    max_nxt    = max_r;
    sum_nxt    = sum_r;
    sum_sq_nxt = sum_sq_r;
    count_nxt  = count_r;
    dup_nxt    = dup_r;
    reord_nxt  = reord_r;
    if (busy_r) begin
      if (item_r.count_it) begin
        sum_nxt    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        sum_sq_nxt = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
        count_nxt  = (count_r == '1) ? count_r : count_r + 1'b1;
        if (item_r.rtt < min_r) begin
          min_nxt = item_r.rtt;
        end
        if (item_r.rtt > max_r) begin
          max_nxt = item_r.rtt;
        end
      end
      if (item_r.is_dup) begin
        dup_nxt = (dup_r == '1) ? dup_r : dup_r + 1'b1;
      end
      if (item_r.is_reorder) begin
        reord_nxt = (reord_r == '1) ? reord_r : reord_r + 1'b1;
      end
    end
    res_item.status        = item_r.status;
    res_item.seq           = item_r.seq;
    res_item.rtt           = item_r.rtt;
    res_item.is_dup        = item_r.is_dup;
    res_item.is_reorder    = item_r.is_reorder;
    res_item.rtt_min       = min_nxt;
    res_item.rtt_max       = max_nxt;
    res_item.rtt_sum       = sum_nxt;
    res_item.rtt_sum_sq    = sum_sq_nxt;
    res_item.rtt_count     = count_nxt;
    res_item.dup_total     = dup_nxt;
    res_item.reorder_total = reord_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      min_r    <= '1;
      max_r    <= '0;
      sum_r    <= '0;
      sum_sq_r <= '0;
      count_r  <= '0;
      dup_r    <= '0;
      reord_r  <= '0;
    end else begin
      busy_r   <= busy_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      sum_r    <= sum_nxt;
      sum_sq_r <= sum_sq_nxt;
      count_r  <= count_nxt;
      dup_r    <= dup_nxt;
      reord_r  <= reord_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      item_r <= mid_item;
      sq_r   <= {{(SQ_W - RTT_W){1'b0}}, mid_item.rtt} * {{(SQ_W - RTT_W){1'b0}}, mid_item.rtt};
    end
  end

endmodule

// File: rtl/core/echo_rtt_dup_reorder_tracker.sv
// Top level of the echo round-trip tracker with duplicate and reorder detection.
`timescale 1ns / 1ps
// Path: an accepted beat is latched with its ring slot, classified and pushed to the middle queue,
// then registered with its square in the back end, accumulated and pushed to the result queue.
// Intake: no new input beat is taken during the read-modify-write of one ring slot.
// The statistics section squares one beat, then accumulates it, before it takes the next.
// Reset: synchronous; while the ring is cleared after rst_n is released, in_full stays high.
module echo_rtt_dup_reorder_tracker #(
  parameter int TRACK_DEPTH = 1024,
  parameter int TIME_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_operation,
  input  logic [ert_pkg::TIME_W-1:0]    in_time_us,
  input  logic [ert_pkg::SEQ_W-1:0]     in_reply_seq,
  input  logic [ert_pkg::TYPE_W-1:0]    in_msg_type,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [1:0]                    out_status,
  output logic [ert_pkg::SEQ_W-1:0]     out_seq,
  output logic [ert_pkg::RTT_W-1:0]     out_rtt_us,
  output logic                          out_is_dup,
  output logic                          out_is_reorder,
  output logic [ert_pkg::RTT_W-1:0]     out_rtt_min_us,
  output logic [ert_pkg::RTT_W-1:0]     out_rtt_max_us,
  output logic [ert_pkg::SUM_W-1:0]     out_rtt_sum_us,
  output logic [ert_pkg::SQ_W-1:0]      out_rtt_sum_sq,
  output logic [ert_pkg::CNT_W-1:0]     out_rtt_count,
  output logic [ert_pkg::CNT_W-1:0]     out_dup_total,
  output logic [ert_pkg::CNT_W-1:0]     out_reorder_total
);

  localparam int MID_W = $bits(ert_pkg::mid_item_t);
  localparam int RES_W = $bits(ert_pkg::res_item_t);

  // Classified beats waiting between the front end and the statistics section.
  ert_pkg::mid_item_t front_item;
  ert_pkg::mid_item_t back_item;
  logic               mid_push, mid_pop, mid_full, mid_empty;

  // Finished result beats waiting for the consumer.
  ert_pkg::res_item_t res_in;
  ert_pkg::res_item_t res_out;
  logic               res_push, res_full;

  // The front end owns the send ring: sends stamp a slot, replies read it back,
  // compute the RTT, test the sequence window and mark an in-window slot as seen. It also
  // tracks the next sequence to assign and the highest sequence replied so far.
  ert_front #(
    .TRACK_DEPTH (TRACK_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_time_us   (in_time_us),
    .in_reply_seq (in_reply_seq),
    .in_msg_type  (in_msg_type),
    .mid_full     (mid_full),
    .mid_push     (mid_push),
    .mid_item     (front_item)
  );

  // The queue lets the front end take a new beat while the back end is still
  // busy with the previous one.
  ert_fifo #(
    .WIDTH (MID_W),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (front_item),
    .pop   (mid_pop),
    .rdata (back_item),
    .full  (mid_full),
    .empty (mid_empty)
  );

  // The back end registers the square of the RTT and folds it into the saturating
  // sums, min/max and counters in the next cycle, producing the complete result beat.
  ert_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_item  (back_item),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_in)
  );

  // Output queue: results wait for a stalled consumer; once both queues fill, intake stops.
  ert_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (out_pop),
    .rdata (res_out),
    .full  (res_full),
    .empty (out_empty)
  );

  assign out_status        = res_out.status;
  assign out_seq           = res_out.seq;
  assign out_rtt_us        = res_out.rtt;
  assign out_is_dup        = res_out.is_dup;
  assign out_is_reorder    = res_out.is_reorder;
  assign out_rtt_min_us    = res_out.rtt_min;
  assign out_rtt_max_us    = res_out.rtt_max;
  assign out_rtt_sum_us    = res_out.rtt_sum;
  assign out_rtt_sum_sq    = res_out.rtt_sum_sq;
  assign out_rtt_count     = res_out.rtt_count;
  assign out_dup_total     = res_out.dup_total;
  assign out_reorder_total = res_out.reorder_total;

endmodule

// File: rtl/core/ert_checker.sv
// Port-level checks of the echo tracker and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ert_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_full,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic [1:0]                    out_status,
  input logic [ert_pkg::SEQ_W-1:0]     out_seq,
  input logic [ert_pkg::RTT_W-1:0]     out_rtt_us,
  input logic                          out_is_dup,
  input logic                          out_is_reorder,
  input logic [ert_pkg::RTT_W-1:0]     out_rtt_min_us,
  input logic [ert_pkg::RTT_W-1:0]     out_rtt_max_us,
  input logic [ert_pkg::CNT_W-1:0]     out_rtt_count
);

  // Right after reset the ring is being cleared and nothing is waiting.
  `ERT_ASSERT_NEXT(a_reset_clear, clk, 1'b0, !rst_n, in_full && out_empty,
                   "bad state after reset")

  // A stalled result beat holds its identity.
  `ERT_ASSERT_NEXT(a_res_hold, clk, !rst_n, !out_empty && !out_pop,
                   !out_empty && $stable(out_seq) && $stable(out_status),
                   "result changed while stalled")

  // Only an in-window reply can carry an RTT or a duplicate flag.
  `ERT_ASSERT_IMPLY(a_rtt_only_in_window, clk, !rst_n,
                    !out_empty && (out_status != ert_pkg::ST_IN_WINDOW),
                    (out_rtt_us == '0) && !out_is_dup, "RTT or duplicate outside window")

  // A duplicate is never also counted as reordered.
  `ERT_ASSERT_IMPLY(a_dup_not_reorder, clk, !rst_n, !out_empty && out_is_dup,
                    !out_is_reorder, "duplicate flagged as reorder")

  // Once anything is counted, the minimum cannot exceed the maximum.
  `ERT_ASSERT_IMPLY(a_min_le_max, clk, !rst_n, !out_empty && (out_rtt_count != '0),
                    out_rtt_min_us <= out_rtt_max_us, "min above max")

endmodule

bind echo_rtt_dup_reorder_tracker ert_port_checker u_ert_checker (.*);
